/* rtl/dabe_pkg.sv */
// Shared types, constants and coding tables of the delta audio bit encoder.
// No dependencies; the other files, the checker apart, refer to it by scoped names.
`default_nettype none

package dabe_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int PKT_BITS_W  = 26;  // widest bit group one sample can cause
    localparam int PKT_LEN_W   = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int RUN_LIMIT   = 256;
    localparam int ZERO_BASE   = 64;
    localparam int LEVEL_MAX   = 5;
    localparam int LEVELS      = 6;

    // Configuration register indexes
    localparam logic [1:0] REG_LEVEL    = 2'd0;
    localparam logic [1:0] REG_RUN_MODE = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic [1:0] CHANNELS_STEREO = 2'd2;

    // Exponent code that announces the wide escape mantissa
    localparam logic [2:0] EXP_ESCAPE = 3'd7;

    typedef logic [2:0] level_t;

    typedef struct packed {
        level_t level;
        logic   run_mode;
        logic   stereo;
    } cfg_t;

    // Bits one sample adds to the stream, LSB first, unused upper bits zero
    typedef struct packed {
        logic [PKT_BITS_W-1:0] bits;
        logic [PKT_LEN_W-1:0]  len;
        logic                  last;
    } packet_t;

    // Mantissa layout per level
    localparam logic [3:0] BASE_SHIFT [LEVELS] = '{4'd4, 4'd3, 4'd2, 4'd1, 4'd1, 4'd1};
    localparam logic [3:0] BOUND_BASE [LEVELS] = '{4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd8};
    localparam logic [3:0] MANT_WIDTH [LEVELS] = '{4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8};
    localparam logic [3:0] ESC_SHIFT  [LEVELS] = '{4'd11, 4'd10, 4'd9, 4'd9, 4'd9, 4'd9};
    localparam logic [3:0] ESC_WIDTH  [LEVELS] = '{4'd6, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8};

endpackage

`default_nettype wire

/* rtl/dabe_front.sv */
// Front end: keeps the per-channel predictors, run count and header progress,
// and turns each accepted sample into one bit group. Depends on dabe_pkg.
`default_nettype none

module dabe_front
(
    input  wire                            clk,
    input  wire                            rst_n,
    input  dabe_pkg::cfg_t                 cfg,
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire  [dabe_pkg::SAMPLE_W-1:0]  in_sample,
    input  wire                            in_last,
    output logic                           pkt_valid,
    input  wire                            pkt_ready,
    output dabe_pkg::packet_t              pkt
);

    typedef struct packed {
        logic [13:0] bits;
        logic [3:0]  len;
    } flush_t;

    // Run flush group: zero code, then 1, 3 or 11 extra bits
    function automatic flush_t run_flush(input logic [8:0] c);
        flush_t     f;
        logic [8:0] cm1;
        cm1 = c - 9'd1;
        if (c < 9'd2) begin
            f.bits = 14'd0;
            f.len  = 4'd4;
        end
        else if (c < 9'd4) begin
            f.bits = {8'd0, cm1[1:0], 1'b1, 3'b000};
            f.len  = 4'd6;
        end
        else begin
            f.bits = {cm1[7:0], 2'b11, 1'b1, 3'b000};
            f.len  = 4'd14;
        end
        return f;
    endfunction

    logic [15:0] pred_reg [2];
    logic [15:0] pred_next [2];
    logic [8:0]  run_cnt_reg, run_cnt_next;
    logic [1:0]  hdr_seen_reg, hdr_seen_next;
    logic        chan_reg, chan_next;

    logic                accept;
    dabe_pkg::level_t    lvl;
    logic [1:0]          chans;
    logic [15:0]         p;
    logic [16:0]         diff;
    logic [16:0]         abs_diff;
    logic                neg;
    logic [15:0]         t;
    logic [6:0]          thr;
    logic                is_zero;
    logic [2:0]          e;
    logic                escape;
    logic [3:0]          bb;
    logic [3:0]          sh;
    logic [3:0]          w;
    logic [15:0]         trunc;
    logic [15:0]         step;
    logic [7:0]          sign_bit;
    logic [7:0]          mask;
    logic [7:0]          mant;
    logic [2:0]          clen;
    logic [11:0]         code_bits;
    logic [3:0]          code_len;
    flush_t              fl_cur;
    flush_t              fl_inc;
    logic [8:0]          cnt_inc;
    logic [3:0]          flen;
    logic [13:0]         fbits;

    assign accept    = in_valid && pkt_ready;
    assign in_ready  = pkt_ready;
    assign pkt_valid = in_valid;

    // Quantise the delta against the channel predictor
    always_comb
    begin
        lvl   = (cfg.level > 3'(dabe_pkg::LEVEL_MAX)) ? 3'(dabe_pkg::LEVEL_MAX) : cfg.level;
        chans = cfg.stereo ? 2'd2 : 2'd1;
        p     = pred_reg[chan_reg];
        diff  = {in_sample[15], in_sample} - {p[15], p};
        neg   = diff[16];
        abs_diff = neg ? (17'd0 - diff) : diff;
        t     = abs_diff[15:0];
        thr   = 7'(dabe_pkg::ZERO_BASE) >> lvl;
        is_zero = t < {9'd0, thr};

        // First exponent whose bound lies above the delta
        bb = dabe_pkg::BOUND_BASE[lvl];
        e  = dabe_pkg::EXP_ESCAPE;
        for (int k = 6; k >= 1; k--)
        begin
            if ((t >> (5'(bb) + 5'(k))) == 16'd0)
                e = 3'(k);
        end
        escape = (e == dabe_pkg::EXP_ESCAPE);
        sh = escape ? dabe_pkg::ESC_SHIFT[lvl] : dabe_pkg::BASE_SHIFT[lvl] + 4'(e);
        w  = escape ? dabe_pkg::ESC_WIDTH[lvl] : dabe_pkg::MANT_WIDTH[lvl];

        trunc    = t >> sh;
        step     = trunc << sh;
        sign_bit = neg ? (8'd1 << (w - 4'd1)) : 8'd0;
        mask     = 8'((9'd1 << w) - 9'd1);
        mant     = (trunc[7:0] | sign_bit) & mask;

        // Exponent code (escape adds a zero bit), then mantissa with sign on top
        clen      = escape ? 3'd4 : 3'd3;
        code_bits = (escape ? 12'(dabe_pkg::EXP_ESCAPE) : 12'(e)) | (12'(mant) << clen);
        code_len  = 4'(clen) + w;

        fl_cur  = run_flush(run_cnt_reg);
        cnt_inc = run_cnt_reg + 9'd1;
        fl_inc  = run_flush(cnt_inc);
        flen    = (run_cnt_reg != 9'd0) ? fl_cur.len : 4'd0;
        fbits   = (run_cnt_reg != 9'd0) ? fl_cur.bits : 14'd0;
    end

    // Build the bit group and the next stream state
    always_comb
    begin
        pred_next     = pred_reg;
        run_cnt_next  = run_cnt_reg;
        hdr_seen_next = hdr_seen_reg;
        pkt.bits      = '0;
        pkt.len       = '0;
        pkt.last      = in_last;

        if (hdr_seen_reg < chans)
        begin
            // Raw header sample loads the predictor
            pred_next[chan_reg] = in_sample;
            hdr_seen_next       = hdr_seen_reg + 2'd1;
            pkt.bits            = dabe_pkg::PKT_BITS_W'(in_sample);
            pkt.len             = 5'd16;
            if (hdr_seen_next == chans)
            begin
                if (cfg.run_mode)
                    run_cnt_next = 9'(chans);
                else
                begin
                    run_cnt_next = 9'd0;
                    pkt.len      = cfg.stereo ? 5'd22 : 5'd19;
                end
            end
        end
        else if (is_zero)
        begin
            if (cfg.run_mode)
            begin
                if (cnt_inc >= 9'(dabe_pkg::RUN_LIMIT))
                begin
                    pkt.bits     = dabe_pkg::PKT_BITS_W'(fl_inc.bits);
                    pkt.len      = 5'(fl_inc.len);
                    run_cnt_next = 9'd0;
                end
                else
                    run_cnt_next = cnt_inc;
            end
            else
                pkt.len = 5'd3;
        end
        else
        begin
            // Flush a pending run, then the coded delta; move the predictor
            pkt.bits = dabe_pkg::PKT_BITS_W'(fbits)
                     | (dabe_pkg::PKT_BITS_W'(code_bits) << flen);
            pkt.len  = 5'(flen) + 5'(code_len);
            run_cnt_next = 9'd0;
            pred_next[chan_reg] = neg ? (p - step) : (p + step);
        end

        chan_next = cfg.stereo ? ~chan_reg : 1'b0;

        // End of stream: back to the opening state
        if (in_last)
        begin
            pred_next[0]  = 16'd0;
            pred_next[1]  = 16'd0;
            run_cnt_next  = 9'd0;
            hdr_seen_next = 2'd0;
            chan_next     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg[0]  <= 16'd0;
            pred_reg[1]  <= 16'd0;
            run_cnt_reg  <= 9'd0;
            hdr_seen_reg <= 2'd0;
            chan_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pred_reg[0]  <= pred_next[0];
            pred_reg[1]  <= pred_next[1];
            run_cnt_reg  <= run_cnt_next;
            hdr_seen_reg <= hdr_seen_next;
            chan_reg     <= chan_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/dabe_queue.sv */
// Short queue of bit groups between the front end and the byte packer.
// Depends on dabe_pkg for the entry type.
`default_nettype none

module dabe_queue
#(
    parameter int DEPTH = dabe_pkg::QUEUE_DEPTH
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  dabe_pkg::packet_t   push_data,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output dabe_pkg::packet_t   pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dabe_pkg::packet_t  store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

/* rtl/dabe_packer.sv */
// Back end: appends bit groups to the partial byte and hands out finished
// bytes one per cycle while out_ready allows, through an output register. Depends on dabe_pkg.
`default_nettype none

module dabe_packer
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                pkt_valid,
    output logic               pkt_ready,
    input  dabe_pkg::packet_t  pkt,
    output logic               out_valid,
    input  wire                out_ready,
    output logic [7:0]         out_byte,
    output logic               out_final
);

    localparam int ACC_W = dabe_pkg::PKT_BITS_W + 7;
    localparam int TOT_W = 6;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [TOT_W-1:0] rem;
    logic [TOT_W-1:0] load_total;
    logic             last_reg, last_next;
    logic             busy_reg, busy_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_final_reg, out_final_next;
    logic             can_emit;

    assign pkt_ready = !busy_reg;
    assign can_emit  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_final = out_final_reg;

    always_comb
    begin
        acc_next       = acc_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_final_next = out_final_reg;
        rem            = total_reg - TOT_W'(8);
        load_total     = total_reg + TOT_W'(pkt.len);

        if (busy_reg)
        begin
            if (can_emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = acc_reg[7:0];
                if (total_reg >= TOT_W'(8))
                begin
                    // Whole byte; stop once only a partial byte remains, unless the stream ends
                    out_final_next = last_reg && (rem == '0);
                    acc_next       = acc_reg >> 8;
                    total_next     = rem;
                    if (rem < TOT_W'(8) && !(last_reg && rem != '0))
                        busy_next = 1'b0;
                end
                else
                begin
                    // End of stream: partial byte, upper bits already zero
                    out_final_next = 1'b1;
                    acc_next       = '0;
                    total_next     = '0;
                    busy_next      = 1'b0;
                end
            end
        end
        else if (pkt_valid)
        begin
            // Append the new group above the held partial byte
            acc_next   = ACC_W'(acc_reg[6:0]) | (ACC_W'(pkt.bits) << total_reg[2:0]);
            total_next = load_total;
            last_next  = pkt.last;
            busy_next  = (load_total >= TOT_W'(8)) || (pkt.last && load_total != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            total_reg     <= '0;
            last_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            total_reg     <= total_next;
            last_reg      <= last_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload, no reset needed
    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_final_reg <= out_final_next;
    end

endmodule

`default_nettype wire

/* rtl/delta_audio_bit_encoder_top.sv */
// Top level of the delta audio bit encoder: configuration registers and the
// front end, queue and byte packer. Depends on dabe_pkg and the dabe_* modules.
//
// Usage:
//   s_axis carries one signed 16-bit sample per item (tdata), channels
//   interleaved left first in stereo; tlast marks the final sample of a stream.
//   m_axis carries the packed LSB-first bitstream one byte per item; tlast is
//   high on the last byte of a stream (the padded partial byte, if any).
//   cfg writes level (index 0), run mode (index 1) and channel count (index 2); it is always
//   ready; it is to be written only while the encoder is idle, which the block does not enforce.
// Timing:
//   A sample is coded in the cycle it is accepted and queued; the packer takes
//   it from the queue when not busy, then moves its bytes to the output register.
//   The packer loads an item and emits all its bytes before it takes the next,
//   so it cannot take a new item while bytes are pending; the queue of
//   QUEUE_DEPTH items lets input continue while bytes drain.
// Reset and stalls:
//   Reset clears predictors, run count, partial byte and registers (mono,
//   level 0, run mode off). A stalled m_axis holds its byte; the packer and
//   then the queue fill, after which s_axis_tready drops.
`default_nettype none

module delta_audio_bit_encoder_top
#(
    parameter int QUEUE_DEPTH = dabe_pkg::QUEUE_DEPTH
)
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // [15:0] sample
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [2:0]  cfg_data
);

    dabe_pkg::level_t   level_reg;
    logic               run_mode_reg;
    logic [1:0]         channels_reg;
    dabe_pkg::cfg_t     cfg;
    logic               q_push_valid;
    logic               q_push_ready;
    dabe_pkg::packet_t  q_push_data;
    logic               q_pop_valid;
    logic               q_pop_ready;
    dabe_pkg::packet_t  q_pop_data;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= 3'd0;
            run_mode_reg <= 1'b0;
            channels_reg <= 2'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dabe_pkg::REG_LEVEL:    level_reg    <= cfg_data;
                dabe_pkg::REG_RUN_MODE: run_mode_reg <= cfg_data[0];
                dabe_pkg::REG_CHANNELS: channels_reg <= cfg_data[1:0];
                default:                ;
            endcase
        end
    end

    assign cfg.level    = level_reg;
    assign cfg.run_mode = run_mode_reg;
    assign cfg.stereo   = (channels_reg == dabe_pkg::CHANNELS_STEREO);

    dabe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .pkt_valid (q_push_valid),
        .pkt_ready (q_push_ready),
        .pkt       (q_push_data)
    );

    dabe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  (q_push_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    dabe_packer u_packer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (q_pop_valid),
        .pkt_ready (q_pop_ready),
        .pkt       (q_pop_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_final (m_axis_tlast)
    );

endmodule

`default_nettype wire

/* rtl/dabe_checker.sv */
// Port-level checks for the delta audio bit encoder, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module dabe_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [7:0]  m_axis_tdata,
    input wire        m_axis_tlast,
    input wire        cfg_valid,
    input wire        cfg_ready
);

    logic seen_in_reg;

    // Note that some sample has gone in since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_in_reg <= 1'b0;
        else if (s_axis_tvalid && s_axis_tready)
            seen_in_reg <= 1'b1;
    end

    // No byte left over from before reset
    a_reset_clears_out: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // A byte only ever follows an accepted sample
    a_out_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> seen_in_reg)
        else $error("output byte without any input");

    // Stalled byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // Configuration channel never back-pressures
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind delta_audio_bit_encoder_top dabe_checker u_dabe_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire

/* verif/dabe_stream_check_pkg.sv */
`timescale 1ns / 1ps
// Bit-exact model and byte checker for the delta audio bit encoder testbench.
// Depends on dabe_pkg for the level type and limit, register indexes, channel code and escape code.

package dabe_stream_check_pkg;

    localparam logic [2:0] ZERO_CODE           = 3'd0;
    localparam logic       ESCAPE_PAD          = 1'b0;
    localparam logic       RUN_SINGLE          = 1'b0;
    localparam logic       RUN_LONGER          = 1'b1;
    localparam logic [1:0] RUN_WIDE_CODE       = 2'd3;
    localparam logic [1:0] REG_SPARE           = 2'd3;
    localparam int         ZERO_THRESHOLD_BASE = 64;
    localparam int         RUN_FLUSH_AT        = 256;
    localparam int         TOP_EXPONENT        = 6;

    // Mantissa layout of one compression level
    typedef struct {
        int base_shift;
        int bound;
        int mant_w;
        int esc_shift;
        int esc_w;
    } layout_t;

    function automatic layout_t layout_for(int lvl);
        case (lvl)
            0:       return '{4, 6, 3, 11, 6};
            1:       return '{3, 6, 4, 10, 7};
            2:       return '{2, 6, 5, 9, 8};
            3:       return '{1, 6, 6, 9, 8};
            4:       return '{1, 7, 7, 9, 8};
            default: return '{1, 8, 8, 9, 8};
        endcase
    endfunction

    class stream_scoreboard;

        typedef struct packed {
            logic [7:0] data;
            logic       fin;
        } out_byte_t;

        // Register copies
        dabe_pkg::level_t level;
        logic             run_mode;
        logic [1:0]       channels;

        // Stream state
        int         pred [2];
        int         run_count;
        logic [7:0] part_bits;
        int         part_cnt;
        int         hdr_seen;
        int         cur_ch;

        logic [7:0] step_bytes [$];
        out_byte_t  expected_bytes [$];
        int         errors;
        int         bytes_seen;

        function new();
            errors     = 0;
            bytes_seen = 0;
            level      = '0;
            run_mode   = 1'b0;
            channels   = 2'd1;
            clear_stream();
        endfunction

        function void clear_stream();
            pred[0]   = 0;
            pred[1]   = 0;
            run_count = 0;
            part_bits = '0;
            part_cnt  = 0;
            hdr_seen  = 0;
            cur_ch    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [2:0] val);
            case (idx)
                dabe_pkg::REG_LEVEL:    level    = val;
                dabe_pkg::REG_RUN_MODE: run_mode = val[0];
                dabe_pkg::REG_CHANNELS: channels = val[1:0];
                default:                ;
            endcase
        endfunction

        function int eff_level();
            return (level > dabe_pkg::LEVEL_MAX) ? dabe_pkg::LEVEL_MAX : int'(level);
        endfunction

        function int zero_limit();
            return ZERO_THRESHOLD_BASE >> eff_level();
        endfunction

        function int bound_bits();
            layout_t lay;
            lay = layout_for(eff_level());
            return lay.bound;
        endfunction

        function int channel_total();
            return (channels == dabe_pkg::CHANNELS_STEREO) ? 2 : 1;
        endfunction

        function bit header_due();
            return hdr_seen < channel_total();
        endfunction

        function int next_pred();
            return pred[cur_ch];
        endfunction

        function int bytes_owed();
            return expected_bytes.size();
        endfunction

        // Append n bits LSB first and peel off every full byte
        function void emit_bits(int n, logic [31:0] v);
            logic [63:0] acc;
            int          total;
            acc   = 64'(part_bits) | ((64'(v) & ((64'd1 << n) - 64'd1)) << part_cnt);
            total = part_cnt + n;
            while (total >= 8)
            begin
                step_bytes.push_back(acc[7:0]);
                acc   = acc >> 8;
                total = total - 8;
            end
            part_bits = acc[7:0];
            part_cnt  = total;
        endfunction

        function void flush_zero_run();
            int c;
            c = run_count;
            emit_bits(3, ZERO_CODE);
            if (c < 2)
                emit_bits(1, RUN_SINGLE);
            else if (c < 4)
            begin
                emit_bits(1, RUN_LONGER);
                emit_bits(2, c - 1);
            end
            else
            begin
                emit_bits(1, RUN_LONGER);
                emit_bits(2, RUN_WIDE_CODE);
                emit_bits(8, c - 1);
            end
            run_count = 0;
        endfunction

        function void count_zero();
            if (run_mode)
            begin
                run_count++;
                if (run_count >= RUN_FLUSH_AT)
                    flush_zero_run();
            end
            else
                emit_bits(3, ZERO_CODE);
        endfunction

        // Code one sample against its channel predictor
        function void code_delta(int s, int ch);
            int      p;
            int      t;
            int      e;
            int      sh;
            int      w;
            int      q;
            logic    sgn;
            layout_t lay;
            lay = layout_for(eff_level());
            p   = pred[ch];
            if (p == s)
            begin
                count_zero();
                return;
            end
            sgn = (p > s);
            t   = sgn ? p - s : s - p;
            if (t < zero_limit())
            begin
                count_zero();
                return;
            end
            if (run_count != 0)
                flush_zero_run();
            e = 1;
            while (e <= TOP_EXPONENT && t >= (1 << (lay.bound + e)))
                e++;
            if (e <= TOP_EXPONENT)
            begin
                emit_bits(3, e);
                sh = lay.base_shift + e;
                w  = lay.mant_w;
            end
            else
            begin
                emit_bits(3, dabe_pkg::EXP_ESCAPE);
                emit_bits(1, ESCAPE_PAD);
                sh = lay.esc_shift;
                w  = lay.esc_w;
            end
            q = (t >> sh) << sh;
            emit_bits(w, (t >> sh) | (int'(sgn) << (w - 1)));
            pred[ch] = sgn ? p - q : p + q;
        endfunction

        // Note an accepted sample and queue the bytes it produces
        function void take_sample(logic [15:0] smp, logic fin);
            int s;
            int chans;
            int ch;
            step_bytes.delete();
            s     = int'($signed(smp));
            chans = channel_total();
            ch    = cur_ch;
            if (hdr_seen < chans)
            begin
                pred[ch] = s;
                emit_bits(16, smp);
                hdr_seen++;
                if (hdr_seen == chans)
                begin
                    if (run_mode)
                        run_count = chans;
                    else
                    begin
                        run_count = 0;
                        for (int i = 0; i < chans; i++)
                            emit_bits(3, ZERO_CODE);
                    end
                end
            end
            else
                code_delta(s, ch);
            cur_ch = (chans == 2) ? (ch ^ 1) : 0;
            if (fin)
            begin
                if (part_cnt > 0)
                    step_bytes.push_back(part_bits);
                clear_stream();
            end
            for (int k = 0; k < step_bytes.size(); k++)
                expected_bytes.push_back('{data: step_bytes[k],
                                           fin: fin && (k == step_bytes.size() - 1)});
        endfunction

        task report(string what);
            errors++;
            $display("%0t: mismatch: %s", $time, what);
        endtask

        // Compare one output byte with the oldest expected one
        task check_byte(logic [7:0] data, logic fin);
            out_byte_t want;
            bytes_seen++;
            if (expected_bytes.size() == 0)
            begin
                report($sformatf("byte %0d: %02h (tlast %0b) with none expected",
                                 bytes_seen, data, fin));
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data)
                report($sformatf("byte %0d: data %02h, expected %02h",
                                 bytes_seen, data, want.data));
            if (fin !== want.fin)
                report($sformatf("byte %0d: tlast %0b, expected %0b",
                                 bytes_seen, fin, want.fin));
        endtask

    endclass

endpackage

/* verif/tb_delta_audio_bit_encoder_top.sv */
`timescale 1ns / 1ps
// Testbench of delta_audio_bit_encoder_top: directed and random sample streams
// checked byte by byte. Depends on dabe_pkg and dabe_stream_check_pkg.

module tb_delta_audio_bit_encoder_top;

    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 80;
    localparam int LONG_RUN      = 260;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = '0;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tready = 1'b0;
    logic       cfg_valid     = 1'b0;
    logic [1:0] cfg_index     = '0;
    logic [2:0] cfg_data      = '0;
    wire        s_axis_tready;
    wire        m_axis_tvalid;
    wire  [7:0] m_axis_tdata;
    wire        m_axis_tlast;
    wire        cfg_ready;

    int tx_idle_pct   = 19;
    int rx_idle_pct   = 73;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int random_items  = 0;

    dabe_stream_check_pkg::stream_scoreboard sb;

    delta_audio_bit_encoder_top uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Check accepted bytes; stall the output at random or for a long hold
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_byte(m_axis_tdata, m_axis_tlast);
        if (hold_requests != hold_served)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task set_idling(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task write_reg(logic [1:0] idx, logic [2:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task release_cfg();
        cfg_valid <= 1'b0;
    endtask

    // Offer one sample, hold until taken, then idle at random
    task send_sample(logic [15:0] smp, logic fin);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        sb.take_sample(smp, fin);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 16'($urandom);
            s_axis_tlast  <= 1'($urandom_range(0, 1));
            do @(posedge clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
    endtask

    // Send the predictor of the next channel moved by d; a header gets a raw sample
    task send_delta(int d, logic fin);
        int s;
        if (sb.header_due())
            s = int'($urandom_range(0, 65535)) - 32768;
        else
        begin
            s = sb.next_pred() + d;
            if (s > 32767)
                s = 32767;
            if (s < -32768)
                s = -32768;
        end
        send_sample(16'(s), fin);
    endtask

    function int zero_delta();
        int mag;
        mag = $urandom_range(0, sb.zero_limit() - 1);
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    // Pick a delta class: zero, one exponent band, escape or a raw noise sample
    task send_random_item(logic fin);
        int r;
        int e;
        int lo;
        int hi;
        int mag;
        int b;
        r = $urandom_range(0, 99);
        b = sb.bound_bits();
        if (r < 25)
        begin
            send_delta(zero_delta(), fin);
            return;
        end
        if (r >= 90)
        begin
            send_sample(16'($urandom), fin);
            return;
        end
        if (r < 80)
        begin
            e   = $urandom_range(1, dabe_stream_check_pkg::TOP_EXPONENT);
            lo  = (e == 1) ? sb.zero_limit() : (1 << (b + e - 1));
            hi  = (1 << (b + e)) - 1;
            mag = $urandom_range(lo, hi);
        end
        else
            mag = $urandom_range(1 << (b + dabe_stream_check_pkg::TOP_EXPONENT), 65535);
        send_delta($urandom_range(0, 1) ? mag : -mag, fin);
    endtask

    // Drop valid and hold off until every expected byte has come
    task wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.bytes_owed() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int r;
        int len;
        int burst;
        bit closes;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Mono, level 0, one zero code per zero: every exponent and both escapes
        write_reg(dabe_pkg::REG_LEVEL, 3'd0);
        write_reg(dabe_pkg::REG_RUN_MODE, 3'd0);
        write_reg(dabe_pkg::REG_CHANNELS, 3'd1);
        write_reg(dabe_stream_check_pkg::REG_SPARE, 3'd5);
        release_cfg();
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_delta(0, 1'b0);
        send_delta(-63, 1'b0);
        send_delta(-100, 1'b0);
        send_delta(200, 1'b0);
        send_delta(-400, 1'b0);
        send_delta(800, 1'b0);
        send_delta(-1600, 1'b0);
        send_delta(3000, 1'b0);
        send_delta(-5000, 1'b0);
        send_sample(16'h0000, 1'b1);

        // Level seven, channel count three, run mode: a last item with no byte
        wait_idle();
        write_reg(dabe_pkg::REG_LEVEL, 3'd7);
        write_reg(dabe_pkg::REG_RUN_MODE, 3'd1);
        write_reg(dabe_pkg::REG_CHANNELS, 3'd3);
        release_cfg();
        send_delta(0, 1'b0);
        send_delta(1, 1'b1);
        send_delta(0, 1'b0);
        send_delta(1, 1'b0);
        send_delta(-1, 1'b0);
        send_delta(2000, 1'b0);
        repeat (4) send_delta(0, 1'b0);

        // Run mode off with a run still counting, then stereo mid-stream
        wait_idle();
        write_reg(dabe_pkg::REG_RUN_MODE, 3'd0);
        release_cfg();
        send_delta(-2000, 1'b0);
        wait_idle();
        write_reg(dabe_pkg::REG_CHANNELS, 3'd2);
        release_cfg();
        send_delta(300, 1'b0);
        send_delta(-300, 1'b0);
        send_delta(0, 1'b0);
        send_delta(700, 1'b1);

        // Level six, channel count zero, a run left pending at the end
        wait_idle();
        write_reg(dabe_pkg::REG_LEVEL, 3'd6);
        write_reg(dabe_pkg::REG_RUN_MODE, 3'd1);
        write_reg(dabe_pkg::REG_CHANNELS, 3'd0);
        release_cfg();
        send_delta(0, 1'b0);
        send_delta(10, 1'b0);
        send_delta(1, 1'b1);

        // Long zero run that reaches the flush limit
        wait_idle();
        write_reg(dabe_pkg::REG_LEVEL, 3'd2);
        write_reg(dabe_pkg::REG_RUN_MODE, 3'd1);
        write_reg(dabe_pkg::REG_CHANNELS, 3'd1);
        release_cfg();
        send_delta(0, 1'b0);
        repeat (LONG_RUN) send_delta(zero_delta(), 1'b0);
        send_delta(5000, 1'b0);
        send_delta(0, 1'b1);

        // Random streams under random settings, idling pattern by thirds
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items < RANDOM_ITEMS / 3)
                set_idling(19, 73);
            else if (random_items < 2 * RANDOM_ITEMS / 3)
                set_idling(73, 19);
            else
                set_idling(0, 0);
            wait_idle();
            write_reg(dabe_pkg::REG_LEVEL, 3'($urandom_range(0, 7)));
            write_reg(dabe_pkg::REG_RUN_MODE, 3'($urandom_range(0, 7)));
            r = $urandom_range(0, 9);
            write_reg(dabe_pkg::REG_CHANNELS,
                      (r < 4) ? 3'd1 : (r < 8) ? 3'd2 : 3'($urandom_range(0, 7)));
            release_cfg();
            len    = $urandom_range(3, 16);
            closes = ($urandom_range(0, 4) != 0);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    burst = $urandom_range(2, 12);
                    repeat (burst) send_delta(zero_delta(), 1'b0);
                    random_items += burst;
                end
                send_random_item(closes && (i == len - 1));
                random_items++;
            end
        end

        // Long output stall while input keeps coming, so the input backs up
        set_idling(0, 0);
        wait_idle();
        write_reg(dabe_pkg::REG_LEVEL, 3'd1);
        write_reg(dabe_pkg::REG_RUN_MODE, 3'd0);
        write_reg(dabe_pkg::REG_CHANNELS, 3'd2);
        release_cfg();
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_random_item(i == 39);

        wait_idle();
        if (sb.bytes_owed() != 0)
            sb.report($sformatf("%0d expected bytes never came", sb.bytes_owed()));
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard limit on run time
    initial
    begin
        #6_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
